@@ rtl/vsmp_pkg.sv @@
// vsmp_pkg: shared constants for the vector set-magnitude block.
// Used by every module in rtl/. No dependencies.
package vsmp_pkg;
	localparam int UNIT_SHIFT = 30;
	localparam int NORM_W = 31;       // normalized magnitudes < 2^30 (plus margin)
	localparam int LEN_W = 32;        // sqrt of sum of two squares < 2^61
	localparam int UNIT_W = 31;       // unit component <= 2^30
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;
endpackage

@@ rtl/vsmp_front.sv @@
// vsmp_front: difference, magnitude split and normalizing shift.
// Depends on vsmp_pkg.
module vsmp_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [VALUE_WIDTH-1:0] point_x,
	input  logic signed [VALUE_WIDTH-1:0] point_y,
	input  logic signed [VALUE_WIDTH-1:0] pivot_x,
	input  logic signed [VALUE_WIDTH-1:0] pivot_y,
	input  logic signed [VALUE_WIDTH-1:0] target_length,
	output logic                          out_valid,
	output logic [vsmp_pkg::NORM_W-1:0]   ax_out,
	output logic [vsmp_pkg::NORM_W-1:0]   ay_out,
	output logic                          negx_out,
	output logic                          negy_out,
	output logic                          zero_out,
	output logic [VALUE_WIDTH-1:0]        tmag_out,
	output logic                          tneg_out,
	output logic signed [VALUE_WIDTH-1:0] cx_out,
	output logic signed [VALUE_WIDTH-1:0] cy_out
);
	import vsmp_pkg::*;
	localparam int DW = VALUE_WIDTH + 1;
	localparam int SW = 6;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] ax, ay, m;
	logic [SW-1:0] msb;
	logic found;

	// stage 1 registers
	logic v_s1, negx_s1, negy_s1, zero_s1, tneg_s1;
	logic [DW-1:0] ax_s1, ay_s1;
	logic [SW-1:0] msb_s1;
	logic [VALUE_WIDTH-1:0] tmag_s1;
	logic signed [VALUE_WIDTH-1:0] cx_s1, cy_s1;

	assign dx = DW'(point_x) - DW'(pivot_x);
	assign dy = DW'(point_y) - DW'(pivot_y);
	assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign m = (ax > ay) ? ax : ay;

	always_comb begin
		msb = '0;
		found = 1'b0;
		for (int i = DW - 1; i >= 0; i--) begin
			if (!found && m[i]) begin
				msb = SW'(i);
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		msb_s1 <= msb;
		negx_s1 <= dx[DW-1];
		negy_s1 <= dy[DW-1];
		zero_s1 <= (dx == '0) && (dy == '0);
		tneg_s1 <= target_length[VALUE_WIDTH-1];
		tmag_s1 <= target_length[VALUE_WIDTH-1] ? VALUE_WIDTH'(-target_length)
		                                        : VALUE_WIDTH'(target_length);
		cx_s1 <= pivot_x;
		cy_s1 <= pivot_y;
	end

	// shift so the larger magnitude has its top bit at position 29
	logic [DW+UNIT_SHIFT-1:0] wx, wy;
	always_comb begin
		wx = (DW+UNIT_SHIFT)'(ax_s1);
		wy = (DW+UNIT_SHIFT)'(ay_s1);
		if (msb_s1 >= SW'(UNIT_SHIFT - 1)) begin
			wx = wx >> (msb_s1 - SW'(UNIT_SHIFT - 1));
			wy = wy >> (msb_s1 - SW'(UNIT_SHIFT - 1));
		end else begin
			wx = wx << (SW'(UNIT_SHIFT - 1) - msb_s1);
			wy = wy << (SW'(UNIT_SHIFT - 1) - msb_s1);
		end
	end

	always_ff @(posedge clk) begin
		ax_out <= wx[NORM_W-1:0];
		ay_out <= wy[NORM_W-1:0];
		negx_out <= negx_s1;
		negy_out <= negy_s1;
		zero_out <= zero_s1;
		tmag_out <= tmag_s1;
		tneg_out <= tneg_s1;
		cx_out <= cx_s1;
		cy_out <= cy_s1;
	end
endmodule

@@ rtl/vsmp_queue.sv @@
// vsmp_queue: short FIFO between front and back parts.
// Depends on vsmp_pkg.
module vsmp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import vsmp_pkg::*;
	logic [WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> (!push || pop))
		else $error("queue overflow");
	no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue underflow");
	count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

@@ rtl/vsmp_sqrt.sv @@
// vsmp_sqrt: pipelined restoring integer square root, one result bit per stage.
// Depends on vsmp_pkg.
module vsmp_sqrt #(
	parameter int IN_W = 62,
	parameter int OUT_W = 31,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [OUT_W-1:0]  root,
	output logic [SIDE_W-1:0] side_out
);
	import vsmp_pkg::*;
	localparam int RW = OUT_W + 2;
	logic              v_q [OUT_W+1];
	logic [2*OUT_W-1:0] n_q [OUT_W+1];
	logic [RW-1:0]     r_q [OUT_W+1];
	logic [OUT_W-1:0]  q_q [OUT_W+1];
	logic [SIDE_W-1:0] s_q [OUT_W+1];

	always_comb begin
		v_q[0] = in_valid;
		n_q[0] = (2*OUT_W)'(radicand);
		r_q[0] = '0;
		q_q[0] = '0;
		s_q[0] = side_in;
	end

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [RW-1:0] rem, trial;
		assign rem = {r_q[k][RW-3:0], n_q[k][2*OUT_W-1 -: 2]};
		assign trial = rem - RW'({q_q[k], 2'b01});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			n_q[k+1] <= n_q[k] << 2;
			s_q[k+1] <= s_q[k];
			if (!trial[RW-1]) begin
				r_q[k+1] <= trial;
				q_q[k+1] <= {q_q[k][OUT_W-2:0], 1'b1};
			end else begin
				r_q[k+1] <= rem;
				q_q[k+1] <= {q_q[k][OUT_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_q[OUT_W];
	assign root = q_q[OUT_W];
	assign side_out = s_q[OUT_W];
endmodule

@@ rtl/vsmp_div.sv @@
// vsmp_div: pipelined restoring divider, (num << 30) / den, one quotient bit a stage.
// Depends on vsmp_pkg.
module vsmp_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 32,
	parameter int Q_W = 31,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [Q_W-1:0]    quot,
	output logic [SIDE_W-1:0] side_out
);
	import vsmp_pkg::*;
	// dividend = num << 30; num < 2^30 * 1.5, den >= 2^29, quotient <= 2^30
	localparam int N_W = NUM_W + UNIT_SHIFT;
	localparam int RW = DEN_W + 1;
	logic              v_q [Q_W+1];
	logic [N_W-1:0]    n_q [Q_W+1];
	logic [RW-1:0]     r_q [Q_W+1];
	logic [Q_W-1:0]    q_q [Q_W+1];
	logic [DEN_W-1:0]  d_q [Q_W+1];
	logic [SIDE_W-1:0] s_q [Q_W+1];

	always_comb begin
		v_q[0] = in_valid;
		// top bits of dividend above the quotient bits are preloaded into remainder
		n_q[0] = {num, UNIT_SHIFT'(0)} << (N_W - Q_W);
		r_q[0] = RW'({num, UNIT_SHIFT'(0)} >> Q_W);
		q_q[0] = '0;
		d_q[0] = den;
		s_q[0] = side_in;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [RW:0] rem, trial;
		assign rem = {r_q[k], n_q[k][N_W-1]};
		assign trial = rem - (RW+1)'(d_q[k]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			n_q[k+1] <= n_q[k] << 1;
			d_q[k+1] <= d_q[k];
			s_q[k+1] <= s_q[k];
			if (!trial[RW]) begin
				r_q[k+1] <= trial[RW-1:0];
				q_q[k+1] <= {q_q[k][Q_W-2:0], 1'b1};
			end else begin
				r_q[k+1] <= rem[RW-1:0];
				q_q[k+1] <= {q_q[k][Q_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_q[Q_W];
	assign quot = q_q[Q_W];
	assign side_out = s_q[Q_W];
endmodule

@@ rtl/vsmp_back.sv @@
// vsmp_back: length, unit vector, scale and saturating add.
// Depends on vsmp_pkg, vsmp_sqrt, vsmp_div.
module vsmp_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [vsmp_pkg::NORM_W-1:0]   ax,
	input  logic [vsmp_pkg::NORM_W-1:0]   ay,
	input  logic                          negx,
	input  logic                          negy,
	input  logic                          zero,
	input  logic [VALUE_WIDTH-1:0]        tmag,
	input  logic                          tneg,
	input  logic signed [VALUE_WIDTH-1:0] cx,
	input  logic signed [VALUE_WIDTH-1:0] cy,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] result_x,
	output logic signed [VALUE_WIDTH-1:0] result_y,
	output logic                          zero_length,
	output logic                          saturated
);
	import vsmp_pkg::*;
	localparam int SIDE_W = 2*NORM_W + 4 + 3*VALUE_WIDTH;
	localparam int SSIDE_W = 4 + 3*VALUE_WIDTH;
	localparam int PW = VALUE_WIDTH + UNIT_W;

	logic [2*NORM_W-1:0] sqx_s1, sqy_s1;
	logic [SIDE_W-1:0] side_s1;
	logic v_s1, v_s2;
	logic [2*NORM_W:0] sum_s2;
	logic [SIDE_W-1:0] side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= (2*NORM_W)'(ax) * (2*NORM_W)'(ax);
		sqy_s1 <= (2*NORM_W)'(ay) * (2*NORM_W)'(ay);
		side_s1 <= {ax, ay, negx, negy, zero, tneg, tmag, cx, cy};
		sum_s2 <= (2*NORM_W+1)'(sqx_s1) + (2*NORM_W+1)'(sqy_s1);
		side_s2 <= side_s1;
	end

	logic sq_v;
	logic [LEN_W-1:0] len;
	logic [SIDE_W-1:0] sq_side;
	vsmp_sqrt #(.IN_W(2*NORM_W+1), .OUT_W(LEN_W), .SIDE_W(SIDE_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2),
		.radicand(sum_s2), .side_in(side_s2),
		.out_valid(sq_v), .root(len), .side_out(sq_side)
	);

	logic [NORM_W-1:0] sax, say;
	logic [SSIDE_W-1:0] rest;
	logic [LEN_W-1:0] den;
	assign {sax, say, rest} = sq_side;
	// guard the zero-length case so the divider never sees zero
	assign den = (len == '0) ? LEN_W'(1) : len;

	logic dvx, dvy;
	logic [UNIT_W-1:0] ux, uy;
	logic [SSIDE_W-1:0] dside, dside_unused;
	vsmp_div #(.NUM_W(NORM_W), .DEN_W(LEN_W), .Q_W(UNIT_W), .SIDE_W(SSIDE_W)) u_divx (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_v), .num(sax), .den(den),
		.side_in(rest), .out_valid(dvx), .quot(ux), .side_out(dside)
	);
	vsmp_div #(.NUM_W(NORM_W), .DEN_W(LEN_W), .Q_W(UNIT_W), .SIDE_W(SSIDE_W)) u_divy (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_v), .num(say), .den(den),
		.side_in(rest), .out_valid(dvy), .quot(uy), .side_out(dside_unused)
	);

	logic nx, ny, zr, tn;
	logic [VALUE_WIDTH-1:0] tm;
	logic signed [VALUE_WIDTH-1:0] bx, by;
	assign {nx, ny, zr, tn, tm, bx, by} = dside;

	// scale stage
	logic v_s3, v_s4;
	logic [PW-1:0] px_s3, py_s3;
	logic nx_s3, ny_s3, zr_s3;
	logic signed [VALUE_WIDTH-1:0] bx_s3, by_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= dvx & dvy;
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		px_s3 <= PW'(tm) * PW'(ux);
		py_s3 <= PW'(tm) * PW'(uy);
		nx_s3 <= nx ^ tn;
		ny_s3 <= ny ^ tn;
		zr_s3 <= zr;
		bx_s3 <= bx;
		by_s3 <= by;
	end

	localparam int SW = VALUE_WIDTH + 2;
	localparam logic signed [SW-1:0] HI = SW'((64'd1 << (VALUE_WIDTH-1)) - 64'd1);
	localparam logic signed [SW-1:0] LO = -HI - SW'(1);
	logic signed [SW-1:0] ox, oy, sx, sy;
	logic clx, cly;
	assign ox = SW'(px_s3 >> UNIT_SHIFT);
	assign oy = SW'(py_s3 >> UNIT_SHIFT);
	assign sx = nx_s3 ? SW'(bx_s3) - ox : SW'(bx_s3) + ox;
	assign sy = ny_s3 ? SW'(by_s3) - oy : SW'(by_s3) + oy;
	assign clx = (sx > HI) || (sx < LO);
	assign cly = (sy > HI) || (sy < LO);

	always_ff @(posedge clk) begin
		if (zr_s3) begin
			result_x <= bx_s3;
			result_y <= by_s3;
			saturated <= 1'b0;
		end else begin
			result_x <= (sx > HI) ? VALUE_WIDTH'(HI) : (sx < LO) ? VALUE_WIDTH'(LO)
			                                                    : VALUE_WIDTH'(sx);
			result_y <= (sy > HI) ? VALUE_WIDTH'(HI) : (sy < LO) ? VALUE_WIDTH'(LO)
			                                                    : VALUE_WIDTH'(sy);
			saturated <= clx | cly;
		end
		zero_length <= zr_s3;
	end
	assign done = v_s4;

	div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dvx == dvy) else $error("dividers out of step");
	zero_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_length) |-> !saturated) else $error("zero flagged saturated");
	zero_pivot: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && zr_s3) |=> (result_x == $past(bx_s3))) else $error("zero not pivot");
endmodule

@@ rtl/vector_set_magnitude_about_pivot_top.sv @@
// Vector set-magnitude about a pivot: moves a point along its ray from a
// pivot to a requested distance, signed fixed point with saturation.
// Channels: an item is transferred when start is high and busy is low; the
// five operands sit on their own ports. Each result shows on result_x,
// result_y, zero_length and saturated for exactly one cycle while done is
// high; the receiver cannot stall, so no backpressure exists downstream.
// Throughput: one item per cycle, sustained (busy is never raised).
// Path: the front part (difference, normalizing shift), the queue, squaring,
// 32 square-root stages, 31 divider stages, then the scale and saturate
// registers, whose last stage drives done.
// What sets latency is the bit-per-stage square root and divider pipelines.
// Reset (arst_n low) empties the queue and clears all valid flags; no result
// is lost or repeated afterward. When point equals pivot, the pivot is
// returned with zero_length set. Widths follow VALUE_WIDTH; the fraction
// position (FRACTION_BITS) cancels in the normalization.
// Depends on vsmp_pkg, vsmp_front, vsmp_queue, vsmp_back.
module vector_set_magnitude_about_pivot_top #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] point_x,
	input  logic signed [VALUE_WIDTH-1:0] point_y,
	input  logic signed [VALUE_WIDTH-1:0] pivot_x,
	input  logic signed [VALUE_WIDTH-1:0] pivot_y,
	input  logic signed [VALUE_WIDTH-1:0] target_length,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] result_x,
	output logic signed [VALUE_WIDTH-1:0] result_y,
	output logic                          zero_length,
	output logic                          saturated
);
	import vsmp_pkg::*;
	localparam int QW = 2*NORM_W + 4 + 3*VALUE_WIDTH;
	// fraction position does not enter the arithmetic; kept for the interface
	localparam int FRAC_UNUSED = FRACTION_BITS;

	logic fv, fnx, fny, fz, ftn;
	logic [NORM_W-1:0] fax, fay;
	logic [VALUE_WIDTH-1:0] ftm;
	logic signed [VALUE_WIDTH-1:0] fcx, fcy;
	logic accept;

	// back end never stalls, so the front is always ready
	assign busy = (FRAC_UNUSED < 0);
	assign accept = start && !busy;

	vsmp_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.point_x(point_x), .point_y(point_y), .pivot_x(pivot_x), .pivot_y(pivot_y),
		.target_length(target_length),
		.out_valid(fv), .ax_out(fax), .ay_out(fay), .negx_out(fnx), .negy_out(fny),
		.zero_out(fz), .tmag_out(ftm), .tneg_out(ftn), .cx_out(fcx), .cy_out(fcy)
	);

	logic qne;
	logic [QW-1:0] qd;
	vsmp_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(fv),
		.push_data({fax, fay, fnx, fny, fz, ftn, ftm, fcx, fcy}),
		.pop(qne), .not_empty(qne), .pop_data(qd)
	);

	logic [NORM_W-1:0] bax, bay;
	logic bnx, bny, bz, btn;
	logic [VALUE_WIDTH-1:0] btm;
	logic signed [VALUE_WIDTH-1:0] bcx, bcy;
	assign {bax, bay, bnx, bny, bz, btn, btm, bcx, bcy} = qd;

	vsmp_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(qne),
		.ax(bax), .ay(bay), .negx(bnx), .negy(bny), .zero(bz),
		.tmag(btm), .tneg(btn), .cx(bcx), .cy(bcy),
		.done(done), .result_x(result_x), .result_y(result_y),
		.zero_length(zero_length), .saturated(saturated)
	);

	never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> !$past(busy)) else $error("spurious result");
	zero_flag_pivot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_length) |-> !saturated) else $error("zero result clipped");
endmodule

@@ bench/tb_vector_set_magnitude_about_pivot_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for vector_set_magnitude_about_pivot_top.
// A directed table runs first, then random vectors, checked by an in-bench predictor.
// Needs only the RTL.
module tb_vector_set_magnitude_about_pivot_top;
	localparam int VW = 32;
	localparam int NORM_SHIFT = 30;
	localparam int N_RANDOM = 1730;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 200;

	typedef logic signed [VW-1:0] coord_t;

	// One input vector, with the expected answer filled in only where it is obvious.
	typedef struct {
		coord_t px, py, cx, cy, tl;
		bit     has_answer;
		coord_t ans_x, ans_y;
		bit     ans_zero, ans_sat;
	} vector_row_t;

	typedef struct {
		coord_t rx, ry;
		bit     zero, sat;
	} moved_point_t;

	localparam coord_t MAXV = {1'b0, {(VW-1){1'b1}}};
	localparam coord_t MINV = {1'b1, {(VW-1){1'b0}}};

	logic   clk, arst_n, start, busy, done, zero_length, saturated;
	coord_t point_x, point_y, pivot_x, pivot_y, target_length, result_x, result_y;

	moved_point_t pending_points[$];
	vector_row_t  directed[$];
	int           mismatches;
	int           idle_cycles;
	int           send_gap_pct;

	vector_set_magnitude_about_pivot_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .pivot_x(pivot_x), .pivot_y(pivot_y),
		.target_length(target_length), .done(done), .result_x(result_x),
		.result_y(result_y), .zero_length(zero_length), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= acc + bitv) begin
				n -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	// Pivot plus signed offset, clamped to the coordinate range.
	function automatic coord_t clamp_add(longint base, longint unsigned off, bit neg,
			ref bit clipped);
		longint s;
		s = neg ? base - longint'(off) : base + longint'(off);
		if (s > longint'(MAXV)) begin
			clipped = 1'b1;
			return MAXV;
		end
		if (s < longint'(MINV)) begin
			clipped = 1'b1;
			return MINV;
		end
		return coord_t'(s);
	endfunction

	function automatic moved_point_t move_about_pivot(vector_row_t v);
		moved_point_t r;
		longint dx, dy;
		longint unsigned ax, ay, m, tm, len, ux, uy;
		bit clipped, tneg;
		dx = longint'(v.px) - longint'(v.cx);
		dy = longint'(v.py) - longint'(v.cy);
		clipped = 1'b0;
		r.rx = v.cx;
		r.ry = v.cy;
		r.zero = (dx == 0 && dy == 0);
		if (!r.zero) begin
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			tneg = v.tl < 0;
			tm = tneg ? -longint'(v.tl) : longint'(v.tl);
			m = ax > ay ? ax : ay;
			while (m >= (64'd1 << NORM_SHIFT)) begin
				ax >>= 1; ay >>= 1; m >>= 1;
			end
			while (m < (64'd1 << (NORM_SHIFT - 1))) begin
				ax <<= 1; ay <<= 1; m <<= 1;
			end
			len = root_floor(ax * ax + ay * ay);
			ux = (ax << NORM_SHIFT) / len;
			uy = (ay << NORM_SHIFT) / len;
			r.rx = clamp_add(v.cx, (tm * ux) >> NORM_SHIFT, (dx < 0) != tneg, clipped);
			r.ry = clamp_add(v.cy, (tm * uy) >> NORM_SHIFT, (dy < 0) != tneg, clipped);
		end
		r.sat = clipped;
		return r;
	endfunction

	task automatic report_mismatch(string what, coord_t got, coord_t want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	// Drive one vector and hold it until the transfer happens.
	task automatic send_vector(vector_row_t v);
		moved_point_t e;
		while (($urandom_range(99, 0)) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= v.px; point_y <= v.py;
		pivot_x <= v.cx; pivot_y <= v.cy;
		target_length <= v.tl;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		e = move_about_pivot(v);
		if (v.has_answer && (e.rx != v.ans_x || e.ry != v.ans_y ||
				e.zero != v.ans_zero || e.sat != v.ans_sat))
			$display("table row disagrees with predictor");
		if (v.has_answer) begin
			e.rx = v.ans_x; e.ry = v.ans_y; e.zero = v.ans_zero; e.sat = v.ans_sat;
		end
		pending_points.push_back(e);
	endtask

	function automatic vector_row_t row(coord_t px, py, cx, cy, tl);
		vector_row_t v;
		v.px = px; v.py = py; v.cx = cx; v.cy = cy; v.tl = tl;
		v.has_answer = 0;
		v.ans_x = 0; v.ans_y = 0; v.ans_zero = 0; v.ans_sat = 0;
		return v;
	endfunction

	function automatic vector_row_t row_ans(coord_t px, py, cx, cy, tl, ax, ay, bit z, s);
		vector_row_t v;
		v = row(px, py, cx, cy, tl);
		v.has_answer = 1;
		v.ans_x = ax; v.ans_y = ay; v.ans_zero = z; v.ans_sat = s;
		return v;
	endfunction

	function automatic coord_t rnd_coord();
		case ($urandom_range(5, 0))
			0: return coord_t'($urandom_range(2000, 0)) - 1000;
			1: return MAXV - coord_t'($urandom_range(3, 0));
			2: return MINV + coord_t'($urandom_range(3, 0));
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Check each result in its one-cycle strobe window.
	always @(posedge clk) begin
		moved_point_t e;
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected result_x", result_x, 0);
			end else begin
				e = pending_points.pop_front();
				if (result_x !== e.rx) report_mismatch("result_x", result_x, e.rx);
				if (result_y !== e.ry) report_mismatch("result_y", result_y, e.ry);
				if (zero_length !== e.zero)
					report_mismatch("zero_length", zero_length, e.zero);
				if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
			end
		end
	end

	// Watchdog: cycles with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		vector_row_t v;
		coord_t cx, cy;
		mismatches = 0;
		idle_cycles = 0;
		send_gap_pct = 17;
		arst_n = 1'b0;
		start = 1'b0;
		point_x = 0; point_y = 0; pivot_x = 0; pivot_y = 0; target_length = 0;

		// point on pivot: pivot comes back with the zero flag
		directed.push_back(row_ans(0, 0, 0, 0, 0, 0, 0, 1, 0));
		directed.push_back(row_ans(MAXV, MINV, MAXV, MINV, 5, MAXV, MINV, 1, 0));
		// axis-aligned vectors give exact lengths
		directed.push_back(row_ans(3, 0, 0, 0, 65536, 65536, 0, 0, 0));
		directed.push_back(row_ans(0, -7, 0, 0, 100, 0, -100, 0, 0));
		directed.push_back(row_ans(5, 0, 0, 0, -40, -40, 0, 0, 0));
		// overshoot the range: clamped
		directed.push_back(row_ans(MAXV, 0, MAXV - 1, 0, 10, MAXV, 0, 0, 1));
		directed.push_back(row_ans(0, MINV, 0, MINV + 1, 10, 0, MINV, 0, 1));
		directed.push_back(row(MAXV, MAXV, MINV, MINV, MAXV));
		directed.push_back(row(MINV, MINV, MAXV, MAXV, MINV));
		directed.push_back(row(MINV, MAXV, MAXV, MINV, MINV));
		directed.push_back(row(MAXV, 0, MINV, 0, MINV));
		directed.push_back(row(1, 1, 0, 0, 65536));
		directed.push_back(row(-1, 2, 0, 0, -65536));
		directed.push_back(row(3, 4, 0, 0, 5 << 16));
		directed.push_back(row(100, -3, 7, 9, MAXV));
		directed.push_back(row(-1, -1, 0, 0, MINV));
		directed.push_back(row(12345, 6789, -555, 42, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_vector(directed[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) send_gap_pct = 63;
			if (n == 2 * N_RANDOM / 3) send_gap_pct = 0;
			cx = rnd_coord();
			cy = rnd_coord();
			v = row(rnd_coord(), rnd_coord(), cx, cy, rnd_coord());
			// occasionally land the point on the pivot
			if ($urandom_range(30, 0) == 0) begin
				v.px = cx; v.py = cy;
			end
			send_vector(v);
		end
		start <= 1'b0;

		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
